### rtl/irn_pkg.sv
package irn_pkg;

  localparam int unsigned ValueW = 12;
  localparam int unsigned CharW  = 8;
  localparam int unsigned PcW    = 5;

  localparam logic [ValueW-1:0] RomanLimit = 12'd3000;

  localparam logic [CharW-1:0] LtrI = 8'h49;
  localparam logic [CharW-1:0] LtrV = 8'h56;
  localparam logic [CharW-1:0] LtrX = 8'h58;
  localparam logic [CharW-1:0] LtrL = 8'h4c;
  localparam logic [CharW-1:0] LtrC = 8'h43;
  localparam logic [CharW-1:0] LtrD = 8'h44;
  localparam logic [CharW-1:0] LtrM = 8'h4d;

  // One microcode word. The step fires when the remainder is at least thr:
  // it emits ch, optionally subtracts thr and jumps to hit, else jumps to miss.
  typedef struct packed {
    logic [ValueW-1:0] thr;
    logic [CharW-1:0]  ch;
    logic              sub;
    logic [PcW-1:0]    hit;
    logic [PcW-1:0]    miss;
  } ucode_t;

  // Word offered by the sequencer to the output register.
  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] ch;
    logic             has_char;
    logic             oor;
    logic             last;
  } item_t;

  // Greedy Roman program: M, CM, D, CD, C, XC, L, XL, X, IX, V, IV, I.
  // Subtractive pairs take two steps; the second one does the subtract.
  function automatic ucode_t ucode(input logic [PcW-1:0] pc);
    ucode_t w;
    case (pc)
      5'd0:  w = '{thr: 12'd1000, ch: LtrM, sub: 1'b1, hit: 5'd0,  miss: 5'd1};
      5'd1:  w = '{thr: 12'd900,  ch: LtrC, sub: 1'b0, hit: 5'd2,  miss: 5'd3};
      5'd2:  w = '{thr: 12'd900,  ch: LtrM, sub: 1'b1, hit: 5'd3,  miss: 5'd3};
      5'd3:  w = '{thr: 12'd500,  ch: LtrD, sub: 1'b1, hit: 5'd4,  miss: 5'd4};
      5'd4:  w = '{thr: 12'd400,  ch: LtrC, sub: 1'b0, hit: 5'd5,  miss: 5'd6};
      5'd5:  w = '{thr: 12'd400,  ch: LtrD, sub: 1'b1, hit: 5'd6,  miss: 5'd6};
      5'd6:  w = '{thr: 12'd100,  ch: LtrC, sub: 1'b1, hit: 5'd6,  miss: 5'd7};
      5'd7:  w = '{thr: 12'd90,   ch: LtrX, sub: 1'b0, hit: 5'd8,  miss: 5'd9};
      5'd8:  w = '{thr: 12'd90,   ch: LtrC, sub: 1'b1, hit: 5'd9,  miss: 5'd9};
      5'd9:  w = '{thr: 12'd50,   ch: LtrL, sub: 1'b1, hit: 5'd10, miss: 5'd10};
      5'd10: w = '{thr: 12'd40,   ch: LtrX, sub: 1'b0, hit: 5'd11, miss: 5'd12};
      5'd11: w = '{thr: 12'd40,   ch: LtrL, sub: 1'b1, hit: 5'd12, miss: 5'd12};
      5'd12: w = '{thr: 12'd10,   ch: LtrX, sub: 1'b1, hit: 5'd12, miss: 5'd13};
      5'd13: w = '{thr: 12'd9,    ch: LtrI, sub: 1'b0, hit: 5'd14, miss: 5'd15};
      5'd14: w = '{thr: 12'd9,    ch: LtrX, sub: 1'b1, hit: 5'd15, miss: 5'd15};
      5'd15: w = '{thr: 12'd5,    ch: LtrV, sub: 1'b1, hit: 5'd16, miss: 5'd16};
      5'd16: w = '{thr: 12'd4,    ch: LtrI, sub: 1'b0, hit: 5'd17, miss: 5'd18};
      5'd17: w = '{thr: 12'd4,    ch: LtrV, sub: 1'b1, hit: 5'd18, miss: 5'd18};
      5'd18: w = '{thr: 12'd1,    ch: LtrI, sub: 1'b1, hit: 5'd18, miss: 5'd18};
      default: w = '{thr: 12'd1,  ch: LtrI, sub: 1'b1, hit: 5'd18, miss: 5'd18};
    endcase
    return w;
  endfunction

endpackage

### rtl/irn_seq.sv
module irn_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [irn_pkg::ValueW-1:0]   value_i,
  input  logic                         adv_i,
  output logic                         busy_o,
  output irn_pkg::item_t               item_o
);

  logic                       busy_q, busy_d;
  logic                       spec_q, spec_d;
  logic                       oor_q, oor_d;
  logic [irn_pkg::PcW-1:0]    pc_q, pc_d;
  logic [irn_pkg::ValueW-1:0] rem_q, rem_d;

  irn_pkg::ucode_t            uw;
  logic                       hit;
  logic [irn_pkg::ValueW-1:0] rem_sub;
  logic                       fin;

  assign uw      = irn_pkg::ucode(pc_q);
  assign hit     = rem_q >= uw.thr;
  assign rem_sub = rem_q - uw.thr;
  // a letter ends the numeral when its subtract leaves nothing
  assign fin     = uw.sub && (rem_sub == '0);

  always_comb begin
    item_o = '0;
    if (busy_q && spec_q) begin
      item_o.valid = 1'b1;
      item_o.oor   = oor_q;
      item_o.last  = 1'b1;
    end else if (busy_q && hit) begin
      item_o.valid    = 1'b1;
      item_o.ch       = uw.ch;
      item_o.has_char = 1'b1;
      item_o.last     = fin;
    end
  end

  always_comb begin
    busy_d = busy_q;
    spec_d = spec_q;
    oor_d  = oor_q;
    pc_d   = pc_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      oor_d  = value_i > irn_pkg::RomanLimit;
      spec_d = (value_i > irn_pkg::RomanLimit) || (value_i == '0);
      pc_d   = '0;
      rem_d  = value_i;
    end else if (busy_q) begin
      if (spec_q) begin
        if (adv_i) begin
          busy_d = 1'b0;
        end
      end else if (!hit) begin
        pc_d = uw.miss;
      end else if (adv_i) begin
        pc_d = uw.hit;
        if (uw.sub) begin
          rem_d = rem_sub;
        end
        if (fin) begin
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      spec_q <= 1'b0;
      oor_q  <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      spec_q <= spec_d;
      oor_q  <= oor_d;
      pc_q   <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;

  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !spec_q |-> rem_q != '0)
    else $error("sequencer running with empty remainder");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_o.valid && item_o.last && adv_i && !start_i |=> !busy_q)
    else $error("sequencer still busy after last word");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && pc_q == '0)
    else $error("start did not launch the program");

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i)
    else $error("start while busy");

endmodule

### rtl/integer_to_roman_numeral.sv
// Converts a 12-bit value to its Roman numeral, one ASCII letter per output word,
// most significant first, last set on the final letter. Zero gives one empty
// word with last set; a value above 3000 gives one word with out_of_range and
// last set and no letter. A value is taken only while the previous one is not
// being expanded. A microcoded sequencer walks a 19-step greedy table (M, CM, D,
// CD, ..., IV, I): each cycle it either emits a letter or skips a table step that
// does not apply, and a letter waits while the output stalls. 2888 takes the
// longest to expand. The next value is taken the cycle after the sequencer
// hands over the last word. The output register holds one word; the sequencer
// waits only while that word is held and stalled.
module integer_to_roman_numeral (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [irn_pkg::ValueW-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [irn_pkg::CharW-1:0]   character_o,
  output logic                        has_char_o,
  output logic                        out_of_range_o,
  output logic                        last_o
);

  logic           busy;
  logic           start;
  logic           adv;
  irn_pkg::item_t item;

  logic                       out_valid_q, out_valid_d;
  logic [irn_pkg::CharW-1:0]  char_q;
  logic                       has_q, oor_q, last_q;

  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;
  assign adv        = !out_valid_q || !out_stall_i;

  irn_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .value_i (value_i),
    .adv_i   (adv),
    .busy_o  (busy),
    .item_o  (item)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (item.valid && adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item.valid && adv) begin
      char_q <= item.ch;
      has_q  <= item.has_char;
      oor_q  <= item.oor;
      last_q <= item.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign character_o    = char_q;
  assign has_char_o     = has_q;
  assign out_of_range_o = oor_q;
  assign last_o         = last_q;

endmodule
